// ===== design/dhtc_pkg.sv =====
// types and constants for the dormant holddown timer control unit
// no dependencies; imported by the top level, dhtc_in_reg, dhtc_eval and the testbench
package dhtc_pkg;

  typedef enum logic [2:0] {
    FuncSidChange  = 3'd0,
    FuncLinkUp     = 3'd1,
    FuncLinkDown   = 3'd2,
    FuncAbort      = 3'd3,
    FuncNewNet     = 3'd4,
    FuncExpiry     = 3'd5,
    FuncControlMsg = 3'd6,
    FuncEnableWr   = 3'd7
  } dhtc_func_e;

  typedef enum logic [1:0] {
    StatusValid   = 2'd0,
    StatusBadType = 2'd1,
    StatusNoMsg   = 2'd2
  } dhtc_status_e;

  localparam int unsigned MsWidth = 15;

  // control type lives in bits 7..5 of the control byte
  localparam logic [2:0] CntlDisable  = 3'b000;
  localparam logic [2:0] CntlSetTimer = 3'b001;

  localparam logic [MsWidth-1:0] DefaultMs    = 15'd0;
  localparam logic [MsWidth-1:0] AltDefaultMs = 15'd5000;
  localparam logic [6:0]         TimeUnitMs   = 7'd100;

  localparam logic [1:0] NetCdma = 2'd1;
  localparam logic [1:0] NetHdr  = 2'd2;

  typedef struct packed {
    dhtc_func_e  func;
    logic        to_dormant;
    logic        orig_fail;
    logic [1:0]  current_network;
    logic [1:0]  next_network;
    logic [7:0]  socm_control;
    logic [7:0]  socm_time;
    logic        enable_value;
  } dhtc_item_t;

  typedef struct packed {
    logic [MsWidth-1:0] hold_time_ms;
    logic               enabled;
    logic               timer_running;
  } dhtc_state_t;

  typedef struct packed {
    logic               start_timer;
    logic               stop_timer;
    logic [MsWidth-1:0] timer_ms;
    logic               started_event;
    logic               stopped_event;
    logic               expired_report;
    dhtc_status_e       socm_status;
    logic               running;
  } dhtc_result_t;

endpackage

// ===== design/dhtc_in_if.sv =====
// event channel into the holddown timer control unit
// plain valid/ready channel, no package dependency
interface dhtc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic       to_dormant;
  logic       orig_fail;
  logic [1:0] current_network;
  logic [1:0] next_network;
  logic [7:0] socm_control;
  logic [7:0] socm_time;
  logic       enable_value;

  modport source (
    output valid, func, to_dormant, orig_fail, current_network, next_network,
           socm_control, socm_time, enable_value,
    input  ready
  );
  modport sink (
    input  valid, func, to_dormant, orig_fail, current_network, next_network,
           socm_control, socm_time, enable_value,
    output ready
  );
endinterface

// ===== design/dhtc_out_if.sv =====
// result channel out of the holddown timer control unit
// plain valid/ready channel, no package dependency
interface dhtc_out_if;
  logic        valid;
  logic        ready;
  logic        start_timer;
  logic        stop_timer;
  logic [14:0] timer_ms;
  logic        started_event;
  logic        stopped_event;
  logic        expired_report;
  logic [1:0]  socm_status;
  logic        running;

  modport source (
    output valid, start_timer, stop_timer, timer_ms, started_event, stopped_event,
           expired_report, socm_status, running,
    input  ready
  );
  modport sink (
    input  valid, start_timer, stop_timer, timer_ms, started_event, stopped_event,
           expired_report, socm_status, running,
    output ready
  );
endinterface

// ===== design/dhtc_cfg_if.sv =====
// configuration write channel carrying the alternate roaming mode bit
// plain valid/ready channel, no package dependency
interface dhtc_cfg_if;
  logic valid;
  logic ready;
  logic jcdma_mode;

  modport source (output valid, jcdma_mode, input ready);
  modport sink   (input valid, jcdma_mode, output ready);
endinterface

// ===== design/dormant_holddown_timer_control_unit.sv =====
// holddown timer control unit for a dormant packet call
// depends on dhtc_pkg, the channel interfaces, dhtc_in_reg and dhtc_eval
//
// Usage:
//   in_i   carries one event per beat (func selects the event, other fields
//          qualify it). out_o gives exactly one result beat per event, in order.
//   cfg_i  writes the alternate roaming mode bit; write it only while no event
//          is in flight. It is always ready.
// Evaluation: an event held in the input register is evaluated combinationally
//   and its result is registered onto out_o once out_o is not stalled.
// Throughput: one event per cycle unless out_o stalls; the timer state
//   update is a single combinational pass from the input register into
//   the state and result registers.
// Reset: hold time 0 ms, enabled, timer not running, alternate mode off,
//   both channels empty.
// Stall: while out_o is stalled the result beat holds; one more event is
//   parked in the input register, after which in_i drops ready.
module dormant_holddown_timer_control_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  dhtc_in_if.sink    in_i,
  dhtc_cfg_if.sink   cfg_i,
  dhtc_out_if.source out_o
);
  import dhtc_pkg::*;

  logic         item_valid;
  dhtc_item_t   item;
  logic         advance;
  dhtc_state_t  state_q;
  dhtc_state_t  state_d;
  dhtc_result_t result_d;
  dhtc_result_t result_q;
  logic         out_valid_q;
  logic         out_valid_d;
  logic         jcdma_mode_q;

  assign advance     = item_valid && (!out_valid_q || out_o.ready);
  assign out_valid_d = advance || (out_valid_q && !out_o.ready);

  dhtc_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .valid_o   (item_valid),
    .item_o    (item)
  );

  dhtc_eval u_eval (
    .item_i       (item),
    .state_i      (state_q),
    .jcdma_mode_i (jcdma_mode_q),
    .state_o      (state_d),
    .result_o     (result_d)
  );

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.hold_time_ms  <= '0;
      state_q.enabled       <= 1'b1;
      state_q.timer_running <= 1'b0;
      out_valid_q           <= 1'b0;
      jcdma_mode_q          <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        jcdma_mode_q <= cfg_i.jcdma_mode;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.start_timer    = result_q.start_timer;
  assign out_o.stop_timer     = result_q.stop_timer;
  assign out_o.timer_ms       = result_q.timer_ms;
  assign out_o.started_event  = result_q.started_event;
  assign out_o.stopped_event  = result_q.stopped_event;
  assign out_o.expired_report = result_q.expired_report;
  assign out_o.socm_status    = result_q.socm_status;
  assign out_o.running        = result_q.running;
endmodule

// ===== design/dhtc_in_reg.sv =====
// input register stage: captures one event beat and holds it until evaluated
// depends on dhtc_pkg and dhtc_in_if
module dhtc_in_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  dhtc_in_if.sink             in_i,
  input  logic                advance_i,
  output logic                valid_o,
  output dhtc_pkg::dhtc_item_t item_o
);
  import dhtc_pkg::*;

  logic       valid_q;
  logic       valid_d;
  dhtc_item_t item_q;
  logic       take;

  // a slot frees up in the same cycle the held event is evaluated
  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;
  assign valid_d    = take || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.func            <= dhtc_func_e'(in_i.func);
      item_q.to_dormant      <= in_i.to_dormant;
      item_q.orig_fail       <= in_i.orig_fail;
      item_q.current_network <= in_i.current_network;
      item_q.next_network    <= in_i.next_network;
      item_q.socm_control    <= in_i.socm_control;
      item_q.socm_time       <= in_i.socm_time;
      item_q.enable_value    <= in_i.enable_value;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

// ===== design/dhtc_eval.sv =====
// event evaluation: next timer state and the result beat for one event
// depends on dhtc_pkg
module dhtc_eval (
  input  dhtc_pkg::dhtc_item_t   item_i,
  input  dhtc_pkg::dhtc_state_t  state_i,
  input  logic                   jcdma_mode_i,
  output dhtc_pkg::dhtc_state_t  state_o,
  output dhtc_pkg::dhtc_result_t result_o
);
  import dhtc_pkg::*;

  logic [MsWidth-1:0] dflt_ms;
  logic [MsWidth-1:0] req_ms;
  logic [MsWidth-1:0] set_ms;
  logic [2:0]         kind;
  logic               stop_now;
  logic               dormant_start;
  logic               restart;

  assign dflt_ms = jcdma_mode_i ? AltDefaultMs : DefaultMs;
  // at most 255 * 100 = 25500, fits the 15 bit field
  assign req_ms  = MsWidth'(item_i.socm_time) * MsWidth'(TimeUnitMs);
  assign kind    = item_i.socm_control[7:5];

  always_comb begin
    if (item_i.socm_time == 8'd0) begin
      set_ms = dflt_ms;
    end else if (jcdma_mode_i || (req_ms > state_i.hold_time_ms)) begin
      set_ms = req_ms;
    end else begin
      set_ms = state_i.hold_time_ms;
    end
  end

  assign stop_now      = state_i.timer_running;
  assign dormant_start = !state_i.timer_running && (state_i.hold_time_ms != '0) &&
                         state_i.enabled && !item_i.orig_fail &&
                         (item_i.current_network == NetCdma);
  // after a set-timer message the running timer is stopped first, so only
  // hold time and enable decide the restart
  assign restart       = (set_ms != '0) && state_i.enabled;

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    result_o.socm_status = StatusNoMsg;

    case (item_i.func)
      FuncSidChange: begin
        state_o.hold_time_ms = dflt_ms;
        if (stop_now) begin
          state_o.timer_running  = 1'b0;
          result_o.stop_timer    = 1'b1;
          result_o.stopped_event = 1'b1;
        end
      end
      FuncLinkUp: begin
        state_o.enabled = 1'b1;
        if (stop_now) begin
          state_o.timer_running  = 1'b0;
          result_o.stop_timer    = 1'b1;
          result_o.stopped_event = 1'b1;
        end
      end
      FuncLinkDown: begin
        if (item_i.to_dormant) begin
          if (dormant_start) begin
            state_o.timer_running  = 1'b1;
            result_o.start_timer   = 1'b1;
            result_o.started_event = 1'b1;
          end
        end else begin
          state_o.enabled      = 1'b1;
          state_o.hold_time_ms = dflt_ms;
          if (stop_now) begin
            state_o.timer_running  = 1'b0;
            result_o.stop_timer    = 1'b1;
            result_o.stopped_event = 1'b1;
          end
        end
      end
      FuncAbort: begin
        state_o.enabled      = 1'b1;
        state_o.hold_time_ms = dflt_ms;
        if (stop_now) begin
          state_o.timer_running  = 1'b0;
          result_o.stop_timer    = 1'b1;
          result_o.stopped_event = 1'b1;
        end
      end
      FuncNewNet: begin
        // only a handoff from 1x to hdr stops the timer
        if (stop_now && (item_i.current_network == NetCdma) &&
            (item_i.next_network == NetHdr)) begin
          state_o.timer_running  = 1'b0;
          result_o.stop_timer    = 1'b1;
          result_o.stopped_event = 1'b1;
        end
      end
      FuncExpiry: begin
        result_o.expired_report = (state_i.hold_time_ms != '0);
        state_o.timer_running   = 1'b0;
        result_o.stopped_event  = 1'b1;
      end
      FuncControlMsg: begin
        if (kind == CntlDisable) begin
          result_o.socm_status = StatusValid;
          state_o.hold_time_ms = dflt_ms;
        end else if (kind == CntlSetTimer) begin
          result_o.socm_status = StatusValid;
          state_o.hold_time_ms = set_ms;
          if (stop_now) begin
            result_o.stop_timer    = 1'b1;
            result_o.stopped_event = 1'b1;
            state_o.timer_running  = restart;
            result_o.start_timer   = restart;
            result_o.started_event = restart;
          end
        end else begin
          result_o.socm_status = StatusBadType;
        end
      end
      FuncEnableWr: begin
        state_o.enabled = item_i.enable_value;
      end
      default: begin
        state_o = state_i;
      end
    endcase

    result_o.timer_ms = state_o.hold_time_ms;
    result_o.running  = state_o.timer_running;
  end
endmodule

// ===== design/dhtc_checker.sv =====
// port-level checks for the holddown timer control unit, bound to the top level
// depends on the top level and its channel interfaces
module dhtc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        start_timer_i,
  input logic        stop_timer_i,
  input logic        started_event_i,
  input logic        stopped_event_i,
  input logic        running_i,
  input logic [14:0] timer_ms_i
);

  // a start command always comes with its notification and leaves the timer running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && start_timer_i |-> started_event_i && running_i)
    else $error("start command without started event or running flag");

  // a stop with no restart leaves the timer idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && stop_timer_i && !start_timer_i |-> stopped_event_i && !running_i)
    else $error("stop command left timer running or had no stopped event");

  // a timer is only started with a nonzero hold time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && start_timer_i |-> timer_ms_i != 15'd0)
    else $error("timer started with zero hold time");

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(timer_ms_i))
    else $error("result beat dropped or changed under stall");

endmodule

bind dormant_holddown_timer_control_unit dhtc_checker u_dhtc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .start_timer_i   (out_o.start_timer),
  .stop_timer_i    (out_o.stop_timer),
  .started_event_i (out_o.started_event),
  .stopped_event_i (out_o.stopped_event),
  .running_i       (out_o.running),
  .timer_ms_i      (out_o.timer_ms)
);

// ===== verif/dormant_holddown_timer_control_unit_tb.sv =====
`timescale 1ns / 1ps
// testbench for dormant_holddown_timer_control_unit: a directed event table, then
// random events in three idling phases, each result beat checked against a fixed row or a local model
// depends on dhtc_pkg, the three channel interfaces and the unit itself
module dormant_holddown_timer_control_unit_tb;
  import dhtc_pkg::*;

  localparam int unsigned QuietLimit    = 2000;
  localparam int unsigned HoldoffCycles = 300;
  localparam int unsigned RandPerPhase  = 460;

  localparam logic [1:0] NetOther    = 2'd0;
  localparam logic [1:0] NetSpare    = 2'd3;
  localparam logic [2:0] CntlBadType = 3'b111;

  typedef struct packed {
    dhtc_item_t   item;
    logic         fixed;
    dhtc_result_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  dhtc_in_if  in_ch ();
  dhtc_out_if out_ch ();
  dhtc_cfg_if cfg_ch ();

  dormant_holddown_timer_control_unit uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .cfg_i  (cfg_ch),
    .out_o  (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // model copy of the timer state and the mode register
  logic [MsWidth-1:0] hold_ms  = '0;
  logic               en_flag  = 1'b1;
  logic               run_flag = 1'b0;
  logic               alt_mode = 1'b0;

  dhtc_result_t pending_results [$];
  dir_row_t     dir_tbl [$];
  int           fails;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           holdoff_trig;
  int           quiet;

  function automatic void halt_timer(inout dhtc_result_t r);
    if (run_flag) begin
      run_flag        = 1'b0;
      r.stop_timer    = 1'b1;
      r.stopped_event = 1'b1;
    end
  endfunction

  function automatic void launch_timer(inout dhtc_result_t r, input logic use_tmr,
                                       input logic [1:0] net);
    if (!run_flag && hold_ms != '0 && en_flag && use_tmr && net == NetCdma) begin
      run_flag        = 1'b1;
      r.start_timer   = 1'b1;
      r.started_event = 1'b1;
    end
  endfunction

  function automatic dhtc_result_t timer_predict(input dhtc_item_t it);
    dhtc_result_t       r;
    logic [MsWidth-1:0] dflt;
    logic [MsWidth-1:0] req;
    r             = '0;
    r.socm_status = StatusNoMsg;
    dflt          = alt_mode ? AltDefaultMs : DefaultMs;
    req           = MsWidth'(it.socm_time) * MsWidth'(TimeUnitMs);
    case (it.func)
      FuncSidChange: begin
        hold_ms = dflt;
        halt_timer(r);
      end
      FuncLinkUp: begin
        en_flag = 1'b1;
        halt_timer(r);
      end
      FuncLinkDown: begin
        if (it.to_dormant) begin
          launch_timer(r, !it.orig_fail, it.current_network);
        end else begin
          halt_timer(r);
          en_flag = 1'b1;
          hold_ms = dflt;
        end
      end
      FuncAbort: begin
        halt_timer(r);
        en_flag = 1'b1;
        hold_ms = dflt;
      end
      FuncNewNet: begin
        // only a handoff from 1x to hdr stops the countdown
        if (it.current_network == NetCdma && it.next_network == NetHdr) halt_timer(r);
      end
      FuncExpiry: begin
        r.expired_report = (hold_ms != '0);
        run_flag         = 1'b0;
        r.stopped_event  = 1'b1;
      end
      FuncControlMsg: begin
        if (it.socm_control[7:5] == CntlDisable) begin
          r.socm_status = StatusValid;
          hold_ms       = dflt;
        end else if (it.socm_control[7:5] == CntlSetTimer) begin
          r.socm_status = StatusValid;
          if (it.socm_time == '0) begin
            hold_ms = dflt;
          end else if (alt_mode || req > hold_ms) begin
            hold_ms = req;
          end
          // a running countdown is stopped and, if the hold time is nonzero and enabled, restarted
          if (run_flag) begin
            halt_timer(r);
            launch_timer(r, 1'b1, NetCdma);
          end
        end else begin
          r.socm_status = StatusBadType;
        end
      end
      default: en_flag = it.enable_value;
    endcase
    r.timer_ms = hold_ms;
    r.running  = run_flag;
    return r;
  endfunction

  function automatic dhtc_item_t mk_event(input dhtc_func_e f, input logic gd, input logic fo,
                                          input logic [1:0] cn, input logic [1:0] nn,
                                          input logic [7:0] ctl, input logic [7:0] tm,
                                          input logic evl);
    dhtc_item_t it;
    it.func            = f;
    it.to_dormant      = gd;
    it.orig_fail       = fo;
    it.current_network = cn;
    it.next_network    = nn;
    it.socm_control    = ctl;
    it.socm_time       = tm;
    it.enable_value    = evl;
    return it;
  endfunction

  function automatic dhtc_result_t mk_result(input logic start, input logic stop,
                                             input logic [MsWidth-1:0] ms,
                                             input logic started, input logic stopped,
                                             input logic expired, input dhtc_status_e st,
                                             input logic running);
    dhtc_result_t r;
    r.start_timer    = start;
    r.stop_timer     = stop;
    r.timer_ms       = ms;
    r.started_event  = started;
    r.stopped_event  = stopped;
    r.expired_report = expired;
    r.socm_status    = st;
    r.running        = running;
    return r;
  endfunction

  // biased towards link down on 1x and well-formed control messages
  function automatic dhtc_item_t rand_event();
    dhtc_item_t it;
    int         r;
    r = $urandom_range(0, 99);
    if (r < 25) it.func = FuncControlMsg;
    else if (r < 50) it.func = FuncLinkDown;
    else it.func = dhtc_func_e'($urandom_range(0, 7));
    it.to_dormant      = ($urandom_range(0, 99) < 75);
    it.orig_fail       = ($urandom_range(0, 99) < 20);
    it.current_network = ($urandom_range(0, 99) < 70) ? NetCdma : 2'($urandom_range(0, 3));
    it.next_network    = ($urandom_range(0, 99) < 50) ? NetHdr : 2'($urandom_range(0, 3));
    r = $urandom_range(0, 99);
    if (r < 45) it.socm_control = {CntlSetTimer, 5'($urandom_range(0, 31))};
    else if (r < 70) it.socm_control = {CntlDisable, 5'($urandom_range(0, 31))};
    else it.socm_control = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 15) it.socm_time = 8'd0;
    else if (r < 25) it.socm_time = 8'd255;
    else it.socm_time = 8'($urandom_range(0, 255));
    it.enable_value = ($urandom_range(0, 99) < 80);
    return it;
  endfunction

  function automatic string fmt_result(input dhtc_result_t r);
    return $sformatf("start=%0b stop=%0b ms=%0d started=%0b stopped=%0b exp=%0b st=%0d run=%0b",
                     r.start_timer, r.stop_timer, r.timer_ms, r.started_event,
                     r.stopped_event, r.expired_report, r.socm_status, r.running);
  endfunction

  task automatic note_fail(input string msg);
    fails++;
    if (fails <= 10) $display("%s", msg);
  endtask

  task automatic send_event(input dhtc_item_t it, input logic fixed, input dhtc_result_t want);
    dhtc_result_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.func            <= it.func;
    in_ch.to_dormant      <= it.to_dormant;
    in_ch.orig_fail       <= it.orig_fail;
    in_ch.current_network <= it.current_network;
    in_ch.next_network    <= it.next_network;
    in_ch.socm_control    <= it.socm_control;
    in_ch.socm_time       <= it.socm_time;
    in_ch.enable_value    <= it.enable_value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pred = timer_predict(it);
    pending_results.push_back(fixed ? want : pred);
  endtask

  // hold the sender until every result beat is back
  task automatic drain_events();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input logic v);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.jcdma_mode <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    alt_mode = v;
  endtask

  task automatic run_phase(input int s_pct, input int r_pct, input int n,
                           input int holdoff_at, input int pause_at);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n; i++) begin
      if (i == holdoff_at) holdoff_trig++;
      if (i == pause_at) drain_events();
      send_event(rand_event(), 1'b0, '0);
    end
  endtask

  // result side: check every beat, stall at random or for a long hold-off
  initial begin
    int           stall_left;
    int           seen;
    dhtc_result_t act;
    dhtc_result_t want;
    stall_left = 0;
    seen       = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        act.start_timer    = out_ch.start_timer;
        act.stop_timer     = out_ch.stop_timer;
        act.timer_ms       = out_ch.timer_ms;
        act.started_event  = out_ch.started_event;
        act.stopped_event  = out_ch.stopped_event;
        act.expired_report = out_ch.expired_report;
        act.socm_status    = dhtc_status_e'(out_ch.socm_status);
        act.running        = out_ch.running;
        if (pending_results.size() == 0) begin
          note_fail($sformatf("unexpected result beat: %s", fmt_result(act)));
        end else begin
          want = pending_results.pop_front();
          if (act.start_timer !== want.start_timer || act.stop_timer !== want.stop_timer ||
              act.timer_ms !== want.timer_ms || act.started_event !== want.started_event ||
              act.stopped_event !== want.stopped_event ||
              act.expired_report !== want.expired_report ||
              act.socm_status !== want.socm_status || act.running !== want.running) begin
            note_fail($sformatf("mismatch: want %s / got %s", fmt_result(want),
                                fmt_result(act)));
          end
        end
      end
      if (holdoff_trig != seen) begin
        seen       = holdoff_trig;
        stall_left = HoldoffCycles;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QuietLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst_n                 = 1'b0;
    fails                 = 0;
    quiet                 = 0;
    holdoff_trig          = 0;
    send_idle_pct         = 0;
    recv_idle_pct         = 0;
    in_ch.valid           <= 1'b0;
    in_ch.func            <= '0;
    in_ch.to_dormant      <= 1'b0;
    in_ch.orig_fail       <= 1'b0;
    in_ch.current_network <= '0;
    in_ch.next_network    <= '0;
    in_ch.socm_control    <= '0;
    in_ch.socm_time       <= '0;
    in_ch.enable_value    <= 1'b0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.jcdma_mode     <= 1'b0;

    // mode 0 throughout; the first rows start from the reset state
    dir_tbl.push_back('{mk_event(FuncExpiry, 0, 0, NetCdma, NetOther, 8'h00, 8'd0, 0),
                        1'b1, mk_result(0, 0, 15'd0, 0, 1, 0, StatusNoMsg, 0)});
    dir_tbl.push_back('{mk_event(FuncControlMsg, 0, 0, NetCdma, NetOther,
                                 {CntlSetTimer, 5'h00}, 8'd255, 0),
                        1'b1, mk_result(0, 0, 15'd25500, 0, 0, 0, StatusValid, 0)});
    dir_tbl.push_back('{mk_event(FuncControlMsg, 0, 0, NetCdma, NetOther,
                                 {CntlBadType, 5'h00}, 8'd0, 0),
                        1'b1, mk_result(0, 0, 15'd25500, 0, 0, 0, StatusBadType, 0)});
    dir_tbl.push_back('{mk_event(FuncLinkDown, 1, 0, NetCdma, NetOther, 8'h00, 8'd0, 0),
                        1'b1, mk_result(1, 0, 15'd25500, 1, 0, 0, StatusNoMsg, 1)});
    // set timer while running: stop then start again, larger value kept
    dir_tbl.push_back('{mk_event(FuncControlMsg, 0, 0, NetCdma, NetOther,
                                 {CntlSetTimer, 5'h1F}, 8'd10, 0),
                        1'b1, mk_result(1, 1, 15'd25500, 1, 1, 0, StatusValid, 1)});
    dir_tbl.push_back('{mk_event(FuncNewNet, 0, 0, NetCdma, NetHdr, 8'h00, 8'd0, 0), 1'b0, '0});
    dir_tbl.push_back('{mk_event(FuncLinkDown, 1, 1, NetCdma, NetOther, 8'h00, 8'd0, 0),
                        1'b0, '0});
    dir_tbl.push_back('{mk_event(FuncLinkDown, 1, 0, NetHdr, NetOther, 8'h00, 8'd0, 0),
                        1'b0, '0});
    dir_tbl.push_back('{mk_event(FuncLinkDown, 1, 0, NetSpare, NetOther, 8'h00, 8'd0, 0),
                        1'b0, '0});
    dir_tbl.push_back('{mk_event(FuncLinkDown, 1, 0, NetOther, NetOther, 8'h00, 8'd0, 0),
                        1'b0, '0});
    dir_tbl.push_back('{mk_event(FuncEnableWr, 1, 1, NetSpare, NetSpare, 8'hFF, 8'hFF, 0),
                        1'b0, '0});
    dir_tbl.push_back('{mk_event(FuncLinkDown, 1, 0, NetCdma, NetOther, 8'h00, 8'd0, 0),
                        1'b0, '0});
    dir_tbl.push_back('{mk_event(FuncLinkUp, 0, 0, NetCdma, NetOther, 8'h00, 8'd0, 0), 1'b0, '0});
    dir_tbl.push_back('{mk_event(FuncLinkDown, 1, 0, NetCdma, NetOther, 8'h00, 8'd0, 0),
                        1'b0, '0});
    dir_tbl.push_back('{mk_event(FuncNewNet, 0, 0, NetCdma, NetCdma, 8'h00, 8'd0, 0), 1'b0, '0});
    dir_tbl.push_back('{mk_event(FuncNewNet, 0, 0, NetHdr, NetHdr, 8'h00, 8'd0, 0), 1'b0, '0});
    dir_tbl.push_back('{mk_event(FuncExpiry, 0, 0, NetCdma, NetOther, 8'h00, 8'd0, 0), 1'b0, '0});
    dir_tbl.push_back('{mk_event(FuncControlMsg, 0, 0, NetCdma, NetOther,
                                 {CntlDisable, 5'h1F}, 8'd77, 0), 1'b0, '0});
    dir_tbl.push_back('{mk_event(FuncLinkDown, 1, 0, NetCdma, NetOther, 8'h00, 8'd0, 0),
                        1'b0, '0});
    dir_tbl.push_back('{mk_event(FuncControlMsg, 0, 0, NetCdma, NetOther,
                                 {CntlSetTimer, 5'h00}, 8'd0, 0), 1'b0, '0});
    dir_tbl.push_back('{mk_event(FuncControlMsg, 0, 0, NetCdma, NetOther,
                                 {CntlSetTimer, 5'h00}, 8'd1, 0), 1'b0, '0});
    dir_tbl.push_back('{mk_event(FuncSidChange, 0, 0, NetCdma, NetOther, 8'h00, 8'd0, 0),
                        1'b0, '0});
    dir_tbl.push_back('{mk_event(FuncAbort, 0, 0, NetCdma, NetOther, 8'h00, 8'd0, 0), 1'b0, '0});
    dir_tbl.push_back('{mk_event(FuncLinkDown, 0, 0, NetCdma, NetOther, 8'h00, 8'd0, 0),
                        1'b0, '0});
    dir_tbl.push_back('{mk_event(FuncEnableWr, 0, 0, NetOther, NetOther, 8'h00, 8'd0, 1),
                        1'b0, '0});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 28;
    recv_idle_pct = 57;
    foreach (dir_tbl[k]) send_event(dir_tbl[k].item, dir_tbl[k].fixed, dir_tbl[k].want);

    drain_events();
    write_mode(1'b1);
    run_phase(28, 57, RandPerPhase, 200, 350);
    drain_events();
    write_mode(1'b0);
    run_phase(57, 28, RandPerPhase, 100, 300);
    drain_events();
    write_mode(1'b1);
    run_phase(0, 0, RandPerPhase, 150, 320);

    drain_events();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) note_fail("result beats still pending at the end");
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
